>>> src/assert_macros.svh
// Assertion macros for the RTL of the binary-weight dot product block.
// No dependencies; taken in by `include where properties are checked.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bwdp_pkg.sv
// Shared types, constants and helpers for the binary-weight block dot product.
// No dependencies; imported by the top, bwdp_ctrl, bwdp_dp and the testbench.
package bwdp_pkg;

  // activation store
  localparam int unsigned AddrW         = 9;
  localparam int unsigned StoreDepth    = 512;
  localparam int unsigned WordW         = 64;
  localparam int unsigned WordsPerBlock = 16;
  localparam int unsigned WordIdxW      = 4;
  localparam int unsigned SignW         = 128;

  // arithmetic widths
  localparam int unsigned ScaleW    = 16;
  localparam int unsigned WsumW     = 12;  // signed sum of one word
  localparam int unsigned BsumW     = 16;  // signed block sum, |x| <= 16384
  localparam int unsigned MantW     = 12;  // signed significand
  localparam int unsigned ProdW     = 28;
  localparam int unsigned ShW       = 5;
  localparam int unsigned ShiftedW  = 57;
  localparam int unsigned SumW      = 60;
  localparam int unsigned SumExtW   = SumW + 1;
  localparam int unsigned RowW      = 16;
  localparam int unsigned BprW      = 6;

  localparam logic [4:0] HalfExpSpecial = 5'h1F;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCKS_PER_ROW = 1'b0,
    CFG_ROWS_IN_TILE   = 1'b1
  } cfg_reg_e;

  // item kinds
  localparam logic OpLoad  = 1'b0;
  localparam logic OpBlock = 1'b1;

  localparam int unsigned MaxBlocksDef = 32;

  // stream layouts
  localparam int unsigned InDataW    = 224;
  localparam int unsigned InAddrLsb  = 0;
  localparam int unsigned InWordLsb  = InAddrLsb + AddrW;
  localparam int unsigned InScaleLsb = InWordLsb + WordW;
  localparam int unsigned InSignLsb  = InScaleLsb + ScaleW;
  localparam int unsigned OutDataW   = 80;
  localparam int unsigned OutPadW    = OutDataW - SumW - RowW;

  typedef struct packed {
    logic                ld_wr;     // write a load item into the store
    logic                blk_load;  // latch a weight block, clear block sum
    logic                rd_en;     // read one store word of the block
    logic [WordIdxW-1:0] widx;
    logic                mul_en;    // block sum times significand
    logic                upd_en;    // accumulate, advance counters
  } cmd_t;

  typedef struct packed {
    logic row_end;
    logic out_busy;
  } st_t;

  // Signed sum of eight int8 lanes, each added (sign bit 1) or subtracted.
  function automatic logic signed [WsumW-1:0] word_sum(input logic [WordW-1:0] w,
                                                      input logic [7:0] s);
    logic signed [WsumW-1:0] acc;
    logic        [WsumW-1:0] a;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      a   = {{(WsumW-8){w[8*k+7]}}, w[8*k +: 8]};
      acc = acc + (s[k] ? a : -a);
    end
    return acc;
  endfunction

endpackage

>>> src/binary_weight_block_dot_product_unit.sv
// Binary-weight block dot product: a load item is written into the store in the
// cycle it is accepted; a weight block steps through accept, 16 reads of the
// single-port activation store at one 64-bit word per cycle, drain, multiply
// and accumulate; a finished row waits till the prior result is taken. Sign bit 1
// adds and 0 subtracts the matching int8 activation; the block sum times the
// exact fp16 scale is summed as signed fixed point with 24 fraction bits and
// saturates at 60 bits. An infinity or NaN scale adds nothing but raises the
// row's tuser flag. Block b of a row reads store words 16*b..16*b+15.
// Depends on bwdp_pkg, bwdp_ctrl, bwdp_dp, bwdp_ram and assert_macros.svh.
`include "assert_macros.svh"

module binary_weight_block_dot_product_unit #(
  parameter int unsigned MaxBlocks = bwdp_pkg::MaxBlocksDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: act_addr, act_word, block_scale, sign_bits_low, sign_bits_high, zero pad
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [bwdp_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  logic                            s_axis_tuser_i,   // op
  // tdata: row_sum, row_index, zero pad
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [bwdp_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                            m_axis_tlast_o,   // last_row
  output logic                            m_axis_tuser_o,   // scale_invalid
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bwdp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bwdp_pkg::CfgDataW-1:0]   cfg_data_i
);
  import bwdp_pkg::*;

  cmd_t            cmd;
  st_t             st;
  logic [SumW-1:0] row_sum;
  logic [RowW-1:0] row_index;

  assign cfg_ready_o = 1'b1;

  bwdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bwdp_dp #(
    .MaxBlocks (MaxBlocks)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .in_addr_i     (s_axis_tdata_i[InAddrLsb +: AddrW]),
    .in_word_i     (s_axis_tdata_i[InWordLsb +: WordW]),
    .in_scale_i    (s_axis_tdata_i[InScaleLsb +: ScaleW]),
    .in_signs_i    (s_axis_tdata_i[InSignLsb +: SignW]),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_idx_i     (cfg_reg_e'(cfg_index_i)),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_sum_o     (row_sum),
    .out_index_o   (row_index),
    .out_last_o    (m_axis_tlast_o),
    .out_invalid_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{OutPadW{1'b0}}, row_index, row_sum};

  `ASSERT_IMPLIES(a_idle_no_work, clk_i, rst_ni, s_axis_tready_o, !cmd.rd_en && !cmd.upd_en, "store read or update while taking input")
  `ASSERT_IMPLIES(a_load_is_transfer, clk_i, rst_ni, cmd.ld_wr, s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == OpLoad), "store write without load transfer")
  `ASSERT_IMPLIES(a_block_timing, clk_i, rst_ni, cmd.blk_load, ##18 cmd.mul_en, "multiply not 18 cycles after block transfer")
  `ASSERT_NEXT(a_row_result, clk_i, rst_ni, cmd.upd_en && st.row_end, m_axis_tvalid_o, "finished row gave no result")

endmodule

>>> src/bwdp_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bwdp_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bwdp_ctrl.sv
// Controller: sequences store reads, multiply and accumulate for a weight block.
// Depends on bwdp_pkg.
module bwdp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_op_i,
  output logic            in_ready_o,
  input  bwdp_pkg::st_t   st_i,
  output bwdp_pkg::cmd_t  cmd_o
);
  import bwdp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_ACC   = 5'b10000
  } ctrl_state_e;

  ctrl_state_e         state_q, state_d;
  logic [WordIdxW-1:0] wcnt_q, wcnt_d;

  always_comb begin
    state_d    = state_q;
    wcnt_d     = wcnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OpBlock) begin
            cmd_o.blk_load = 1'b1;
            wcnt_d         = '0;
            state_d        = ST_READ;
          end else begin
            cmd_o.ld_wr = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.widx  = wcnt_q;
        wcnt_d      = wcnt_q + WordIdxW'(1);
        if (wcnt_q == WordIdxW'(WordsPerBlock - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last word leaves the store this cycle
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        // a finished row waits until the result register is free
        if (!(st_i.row_end && st_i.out_busy)) begin
          cmd_o.upd_en = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      wcnt_q  <= wcnt_d;
    end
  end

endmodule

>>> src/bwdp_dp.sv
// Datapath: activation store, block sum, scale decode, fixed-point row accumulator,
// counters, configuration and result register. Depends on bwdp_pkg and bwdp_ram.
module bwdp_dp #(
  parameter int unsigned MaxBlocks = bwdp_pkg::MaxBlocksDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bwdp_pkg::cmd_t                   cmd_i,
  output bwdp_pkg::st_t                    st_o,
  input  logic [bwdp_pkg::AddrW-1:0]       in_addr_i,
  input  logic [bwdp_pkg::WordW-1:0]       in_word_i,
  input  logic [bwdp_pkg::ScaleW-1:0]      in_scale_i,
  input  logic [bwdp_pkg::SignW-1:0]       in_signs_i,
  input  logic                             cfg_we_i,
  input  bwdp_pkg::cfg_reg_e               cfg_idx_i,
  input  logic [bwdp_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [bwdp_pkg::SumW-1:0]        out_sum_o,
  output logic [bwdp_pkg::RowW-1:0]        out_index_o,
  output logic                             out_last_o,
  output logic                             out_invalid_o
);
  import bwdp_pkg::*;

  localparam int unsigned BcW  = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned CmpW = (BcW + 1 > BprW + 1) ? BcW + 1 : BprW + 1;

  // ---- store ----
  logic [AddrW+BcW-1:0] base_full;
  logic [AddrW-1:0]     rd_addr, ram_addr;
  logic [WordW-1:0]     ram_rdata;
  logic [BcW-1:0]       blk_cnt_q, blk_cnt_d;

  assign base_full = {{AddrW{1'b0}}, blk_cnt_q} << WordIdxW;
  assign rd_addr   = base_full[AddrW-1:0] + AddrW'(cmd_i.widx);
  assign ram_addr  = cmd_i.ld_wr ? in_addr_i : rd_addr;

  bwdp_ram #(
    .Width (WordW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ld_wr),
    .addr_i  (ram_addr),
    .wdata_i (in_word_i),
    .rdata_o (ram_rdata)
  );

  // ---- block sum ----
  logic [ScaleW-1:0]       scale_q;
  logic [SignW-1:0]        signs_q;
  logic                    rd_vld_q;
  logic [WordIdxW-1:0]     rd_idx_q;
  logic signed [BsumW-1:0] bsum_q, bsum_d;
  logic [7:0]              word_signs;

  assign word_signs = signs_q[{rd_idx_q, 3'b000} +: 8];

  always_comb begin
    bsum_d = bsum_q;
    if (cmd_i.blk_load) begin
      bsum_d = '0;
    end else if (rd_vld_q) begin
      bsum_d = bsum_q + BsumW'(word_sum(ram_rdata, word_signs));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_load) begin
      scale_q <= in_scale_i;
      signs_q <= in_signs_i;
    end
    rd_idx_q <= cmd_i.widx;
    bsum_q   <= bsum_d;
  end

  // ---- scale decode and multiply ----
  logic [4:0]              sc_exp;
  logic                    sc_bad;
  logic [MantW-1:0]        mag;
  logic signed [MantW-1:0] mant_s;
  logic [ShW-1:0]          sh;
  logic signed [ProdW-1:0] prod_q;

  assign sc_exp = scale_q[14:10];
  assign sc_bad = (sc_exp == HalfExpSpecial);
  assign mag    = {1'b0, (sc_exp != 5'd0), scale_q[9:0]};
  assign mant_s = scale_q[15] ? -mag : mag;
  // subnormal: no hidden bit, weight 2^-24; normal: shift by exponent - 1
  assign sh     = (sc_exp == 5'd0) ? '0 : sc_exp - 5'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(bsum_q) * ProdW'(mant_s);
    end
  end

  // ---- accumulate with saturation ----
  logic signed [ShiftedW-1:0] shifted;
  logic signed [SumExtW-1:0]  sum_w;
  logic signed [SumW-1:0]     acc_q, acc_nx, sat;
  logic                       inv_q, inv_nx;

  assign shifted = ShiftedW'(prod_q) <<< sh;
  assign sum_w   = SumExtW'(acc_q) + SumExtW'(shifted);

  always_comb begin
    if (sum_w[SumW] != sum_w[SumW-1]) begin
      sat = sum_w[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sat = sum_w[SumW-1:0];
    end
  end

  assign acc_nx = sc_bad ? acc_q : sat;
  assign inv_nx = inv_q | sc_bad;

  // ---- counters and configuration ----
  logic [BprW-1:0] bpr_q;
  logic [RowW-1:0] rit_q, row_cnt_q, nrows;
  logic [CmpW-1:0] bpr_ext, nblk;
  logic            row_end, last_row;

  assign bpr_ext  = CmpW'(bpr_q);
  assign nblk     = (bpr_q == '0) ? CmpW'(1) :
                    (bpr_ext > CmpW'(MaxBlocks)) ? CmpW'(MaxBlocks) : bpr_ext;
  assign row_end  = (CmpW'(blk_cnt_q) + CmpW'(1)) >= nblk;
  assign nrows    = (rit_q == '0) ? RowW'(1) : rit_q;
  assign last_row = ({1'b0, row_cnt_q} + (RowW+1)'(1)) >= {1'b0, nrows};
  assign blk_cnt_d = blk_cnt_q + BcW'(1);

  assign st_o.row_end  = row_end;
  assign st_o.out_busy = out_valid_o & ~out_ready_i;

  // ---- result register ----
  logic                   out_vld_q;
  logic signed [SumW-1:0] out_sum_q;
  logic [RowW-1:0]        out_idx_q;
  logic                   out_last_q, out_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      acc_q     <= '0;
      inv_q     <= 1'b0;
      blk_cnt_q <= '0;
      row_cnt_q <= '0;
      bpr_q     <= BprW'(1);
      rit_q     <= RowW'(1);
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLOCKS_PER_ROW: bpr_q <= cfg_data_i[BprW-1:0];
          CFG_ROWS_IN_TILE:   rit_q <= cfg_data_i[RowW-1:0];
          default: begin
          end
        endcase
      end
      if (out_vld_q && out_ready_i && !(cmd_i.upd_en && row_end)) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.upd_en) begin
        if (row_end) begin
          out_vld_q <= 1'b1;
          acc_q     <= '0;
          inv_q     <= 1'b0;
          blk_cnt_q <= '0;
          row_cnt_q <= last_row ? '0 : row_cnt_q + RowW'(1);
        end else begin
          acc_q     <= acc_nx;
          inv_q     <= inv_nx;
          blk_cnt_q <= blk_cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en && row_end) begin
      out_sum_q  <= acc_nx;
      out_idx_q  <= row_cnt_q;
      out_last_q <= last_row;
      out_inv_q  <= inv_nx;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_sum_o     = out_sum_q;
  assign out_index_o   = out_idx_q;
  assign out_last_o    = out_last_q;
  assign out_invalid_o = out_inv_q;

endmodule

>>> tb/binary_weight_block_dot_product_unit_tb.sv
// Self-checking testbench for binary_weight_block_dot_product_unit: directed table, then
// random phases over several register settings; row results are checked against a predictor or the table.
// Depends on bwdp_pkg and the block's RTL.
module binary_weight_block_dot_product_unit_tb;
  import bwdp_pkg::*;

  localparam int unsigned DirN       = 27;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit = 200000;
  localparam longint      SumHi      = 64'sd576460752303423487;
  localparam longint      SumLo      = -SumHi - 1;
  localparam logic [63:0] MinAct     = 64'h8080_8080_8080_8080;
  localparam logic [63:0] AllSet     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint      Pow38      = 64'sd274877906944;

  typedef struct packed {
    logic        op;
    logic [8:0]  addr;
    logic [63:0] word;
    logic [15:0] scale;
    logic [63:0] lo;
    logic [63:0] hi;
  } bw_item_t;

  typedef struct packed {
    logic signed [59:0] sum;
    logic [15:0]        idx;
    logic               last;
    logic               inv;
  } row_res_t;

  typedef struct packed {
    bw_item_t           it;
    logic               typed;  // row of index 0, last of a one-row tile
    logic signed [59:0] sum;
    logic               inv;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [InDataW-1:0]  in_data = '0;
  logic                in_op = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OutDataW-1:0] out_data;
  logic                out_last;
  logic                out_user;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CFG_BLOCKS_PER_ROW;
  logic [CfgDataW-1:0] cfg_data = '0;

  int unsigned idle_pct = 29;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;

  // predictor state
  logic [63:0] act_store [StoreDepth];
  bit          act_loaded [StoreDepth];
  int unsigned blk_ctr = 0;
  longint      row_acc = 0;
  int unsigned row_ctr = 0;
  bit          inv_seen = 1'b0;
  int unsigned cfg_bpr = 1;
  int unsigned cfg_rows = 1;
  row_res_t    pending_rows [$];

  dir_row_t    stim_table [DirN];

  binary_weight_block_dot_product_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_op),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tlast_o  (out_last),
    .m_axis_tuser_o  (out_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Applies one accepted item to the predicted state; done is set when a row completes.
  task automatic predict_row_sum(input bw_item_t it, output bit done, output row_res_t r);
    int unsigned nblk;
    int unsigned nrows;
    logic [4:0]  e;
    logic [9:0]  m;
    longint      mag;
    longint      sc;
    longint      acc;
    int          bsum;
    int          a;
    logic [127:0] signs;
    logic [63:0] w;
    bit          last;
    done = 1'b0;
    r = '0;
    if (it.op == OpLoad) begin
      act_store[it.addr] = it.word;
      act_loaded[it.addr] = 1'b1;
    end else begin
      nblk = (cfg_bpr == 0) ? 1 : ((cfg_bpr > MaxBlocksDef) ? MaxBlocksDef : cfg_bpr);
      e = it.scale[14:10];
      m = it.scale[9:0];
      if (e == HalfExpSpecial) begin
        inv_seen = 1'b1;
      end else begin
        mag = (e == 5'd0) ? longint'(m) : (longint'({1'b1, m}) << (e - 5'd1));
        sc = it.scale[15] ? -mag : mag;
        signs = {it.hi, it.lo};
        bsum = 0;
        for (int j = 0; j < WordsPerBlock; j++) begin
          w = act_store[(blk_ctr * WordsPerBlock + j) % StoreDepth];
          for (int k = 0; k < 8; k++) begin
            a = int'($signed(w[8*k +: 8]));
            bsum += signs[8*j + k] ? a : -a;
          end
        end
        acc = row_acc + longint'(bsum) * sc;
        if (acc > SumHi) acc = SumHi;
        if (acc < SumLo) acc = SumLo;
        row_acc = acc;
      end
      if (blk_ctr + 1 < nblk) begin
        blk_ctr++;
      end else begin
        nrows = (cfg_rows == 0) ? 1 : cfg_rows;
        last = (row_ctr + 1 >= nrows);
        r.sum = row_acc[59:0];
        r.idx = row_ctr[15:0];
        r.last = last;
        r.inv = inv_seen;
        done = 1'b1;
        row_ctr = last ? 0 : ((row_ctr + 1) & 32'hFFFF);
        blk_ctr = 0;
        row_acc = 0;
        inv_seen = 1'b0;
      end
    end
  endtask

  function automatic bw_item_t rand_item(input logic op, input logic [8:0] addr);
    bw_item_t    it;
    int unsigned pick;
    logic [7:0]  b;
    it.op = op;
    it.addr = addr;
    it.word = {$urandom, $urandom};
    it.lo = {$urandom, $urandom};
    it.hi = {$urandom, $urandom};
    it.scale = 16'($urandom);
    pick = $urandom_range(99);
    if (op == OpLoad) begin
      if (pick < 12) begin
        b = pick[0] ? 8'h80 : 8'h7F;
        it.word = {8{b}};
      end
    end else begin
      if (pick < 8) begin
        it.scale[14:10] = HalfExpSpecial;
      end else if (pick < 18) begin
        it.scale[14:10] = 5'd0;
      end else if (pick < 24) begin
        it.lo = pick[0] ? '0 : AllSet;
        it.hi = it.lo;
      end
    end
    return it;
  endfunction

  function automatic dir_row_t blk_row(input logic [15:0] scale, input logic [63:0] lo,
                                       input logic [63:0] hi, input logic typed,
                                       input logic signed [59:0] sum, input logic inv);
    return '{'{OpBlock, 9'd0, 64'd0, scale, lo, hi}, typed, sum, inv};
  endfunction

  task automatic send_item(input bw_item_t it, input bit typed, input row_res_t typed_res);
    int unsigned gap;
    bit          done;
    row_res_t    r;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_op <= it.op;
    in_data <= InDataW'({it.hi, it.lo, it.scale, it.word, it.addr});
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_row_sum(it, done, r);
    if (done) pending_rows.push_back(typed ? typed_res : r);
  endtask

  // Waits for every predicted row, then for a block still in flight mid-row.
  task automatic drain_rows();
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [15:0] bpr, input logic [15:0] rows,
                           input int unsigned count, input int unsigned idle);
    int unsigned base;
    in_valid <= 1'b0;
    drain_rows();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BLOCKS_PER_ROW;
    cfg_data <= bpr;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_bpr = 32'(bpr[BprW-1:0]);
    cfg_index <= CFG_ROWS_IN_TILE;
    cfg_data <= rows;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_rows = 32'(rows);
    cfg_valid <= 1'b0;
    idle_pct = idle;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 20) begin
        send_item(rand_item(OpLoad, 9'($urandom)), 1'b0, '0);
      end else begin
        // never let a block read a word that has not been loaded
        base = blk_ctr * WordsPerBlock;
        for (int j = 0; j < WordsPerBlock; j++)
          if (!act_loaded[(base + j) % StoreDepth])
            send_item(rand_item(OpLoad, 9'(base + j)), 1'b0, '0);
        send_item(rand_item(OpBlock, 9'($urandom)), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    row_res_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
      if (rst_ni && out_valid && out_ready) begin
        if (pending_rows.size() == 0) begin
          $error("row result transfer with no row pending");
          mismatches++;
        end else begin
          want = pending_rows.pop_front();
          if ($signed(out_data[SumW-1:0]) != want.sum) begin
            $error("row_sum: expected %0d, got %0d", want.sum, $signed(out_data[SumW-1:0]));
            mismatches++;
          end
          if (out_data[SumW +: RowW] != want.idx) begin
            $error("row_index: expected %0d, got %0d", want.idx, out_data[SumW +: RowW]);
            mismatches++;
          end
          if (out_last != want.last) begin
            $error("last_row: expected %0b, got %0b", want.last, out_last);
            mismatches++;
          end
          if (out_user != want.inv) begin
            $error("scale_invalid: expected %0b, got %0b", want.inv, out_user);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Store words 0..15 all hold -128, so the block sum is -128 * (2*pos - 128).
    for (int i = 0; i < WordsPerBlock; i++)
      stim_table[i] = '{'{OpLoad, 9'(i), MinAct, 16'h0, 64'h0, 64'h0}, 1'b0, 60'sd0, 1'b0};
    stim_table[16] = blk_row(16'h3C00, '0, '0, 1'b1, 60'(Pow38), 1'b0);
    stim_table[17] = blk_row(16'h3C00, AllSet, AllSet, 1'b1, 60'(-Pow38), 1'b0);
    stim_table[18] = blk_row(16'h0000, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                             1'b1, 60'sd0, 1'b0);
    stim_table[19] = blk_row(16'h0001, '0, '0, 1'b1, 60'sd16384, 1'b0);
    stim_table[20] = blk_row(16'h8001, '0, '0, 1'b1, -60'sd16384, 1'b0);
    stim_table[21] = blk_row(16'h03FF, '0, '0, 1'b0, 60'sd0, 1'b0);
    stim_table[22] = blk_row(16'h0400, AllSet, AllSet, 1'b0, 60'sd0, 1'b0);
    stim_table[23] = blk_row(16'h7BFF, '0, '0, 1'b0, 60'sd0, 1'b0);
    stim_table[24] = blk_row(16'hFBFF, '0, '0, 1'b0, 60'sd0, 1'b0);
    // infinity and NaN scales add nothing but flag the row
    stim_table[25] = blk_row(16'h7C00, AllSet, '0, 1'b1, 60'sd0, 1'b1);
    stim_table[26] = blk_row(16'hFFFF, '0, AllSet, 1'b1, 60'sd0, 1'b1);

    for (int i = 0; i < DirN; i++)
      send_item(stim_table[i].it, stim_table[i].typed,
                '{stim_table[i].sum, 16'd0, 1'b1, stim_table[i].inv});

    run_phase(16'd2, 16'd3, 60, 29);
    run_phase(16'd0, 16'd0, 60, 29);        // zero counts act as one
    run_phase(16'd5, 16'hFFFF, 60, 0);      // back-to-back, no idling
    run_phase(16'd32, 16'd4, 80, 29);
    run_phase(16'hFFE1, 16'd2, 50, 29);     // 33 after masking, clamps to 32
    run_phase(16'd1, 16'd7, 70, 29);

    in_valid <= 1'b0;
    drain_rows();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
